FILE: design/asdq_pkg.sv
`timescale 1ns / 1ps
// Package with the shared constants, codes and state type of the deadline queue.
package asdq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int ROUTE_BITS_DEF  = 8;
  localparam int TIME_W          = 32;
  localparam int SIZE_W          = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SERVE  = 1'b1;

  localparam logic MODE_FIFO = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SERVE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_SIZE = 2'd1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_WR,
    ST_SRV_HEAD,
    ST_SRV_SCAN,
    ST_REM,
    ST_REM_MV,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

FILE: design/asdq_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
module asdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/arrival_sorted_deadline_queue.sv
`timescale 1ns / 1ps
// Top level of the arrival-sorted deadline queue: control sequencer and entry memory.
// The queue holds up to QUEUE_DEPTH packets in one RAM, sorted by arrival time, and
// handles one command at a time through a single read and a single write port. An
// insert steps through accept, one compare per entry with a later arrival that moves
// up, one more compare when the search stops on an entry with an earlier or equal
// arrival, then write and result. A serve reads the head; in deadline mode with the
// clock past the head it scans each entry read after the head (the arrived entries and
// the first one that has not arrived), then starts the removal, moves down each entry
// behind the chosen one, finishes and delivers; a full-queue insert or an empty-queue
// serve goes straight to the result. The memory port moves one entry per cycle. The next
// command is taken while a result still waits on the output register.
module arrival_sorted_deadline_queue #(
  parameter int QUEUE_DEPTH = asdq_pkg::QUEUE_DEPTH_DEF,
  parameter int ROUTE_BITS  = asdq_pkg::ROUTE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [asdq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [asdq_pkg::SIZE_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_cmd,
  input  logic [ROUTE_BITS-1:0]           in_route_id,
  input  logic [asdq_pkg::TIME_W-1:0]     in_send_time,
  input  logic [asdq_pkg::TIME_W-1:0]     in_arrival_time,
  input  logic signed [asdq_pkg::TIME_W-1:0] in_deadline_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [ROUTE_BITS-1:0]           out_route,
  output logic [asdq_pkg::TIME_W-1:0]     out_send_time,
  output logic [asdq_pkg::TIME_W-1:0]     out_arrival,
  output logic signed [asdq_pkg::TIME_W-1:0] out_deadline,
  output logic [asdq_pkg::TIME_W-1:0]     out_service_start
);

  localparam int TW = asdq_pkg::TIME_W;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = ROUTE_BITS + 3 * TW;

  asdq_pkg::state_t  st_r, st_nxt;
  asdq_pkg::status_t stat_r, stat_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] pick_r, pick_nxt;
  logic [TW-1:0] clk_r, clk_nxt;
  logic          mode_r;
  logic [asdq_pkg::SIZE_W-1:0] psize_r;
  logic [EW-1:0] new_r, new_nxt;
  logic [EW-1:0] best_r, best_nxt;
  logic [TW-1:0] sstart_r, sstart_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r;
  logic [EW-1:0] out_ent_r;
  logic [TW-1:0] out_sstart_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [TW-1:0] rd_arr, new_arr, best_dl, rd_dl;
  logic [CW-1:0] k_inc, k_dec, k_dec2, pick_inc, cnt_m1;
  logic [TW:0]   clk_sum;
  logic          out_free;

  asdq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_arr   = ram_rdata[2*TW-1:TW];
  assign rd_dl    = ram_rdata[TW-1:0];
  assign new_arr  = new_r[2*TW-1:TW];
  assign best_dl  = best_r[TW-1:0];
  assign k_inc    = k_r + CW'(1);
  assign k_dec    = k_r - CW'(1);
  assign k_dec2   = k_r - CW'(2);
  assign pick_inc = pick_r + CW'(1);
  assign cnt_m1   = cnt_r - CW'(1);
  assign clk_sum  = {1'b0, clk_r} + {{(TW + 1 - asdq_pkg::SIZE_W){1'b0}}, psize_r};
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall = (st_r != asdq_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= asdq_pkg::ST_IDLE;
      cnt_r       <= '0;
      clk_r       <= '0;
      mode_r      <= 1'b0;
      psize_r     <= asdq_pkg::SIZE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      clk_r       <= clk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en && cfg_index == asdq_pkg::CFG_SERVE_MODE) begin
        mode_r <= cfg_data[0];
      end
      if (cfg_wr_en && cfg_index == asdq_pkg::CFG_PACKET_SIZE) begin
        psize_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    stat_r   <= stat_nxt;
    k_r      <= k_nxt;
    pick_r   <= pick_nxt;
    new_r    <= new_nxt;
    best_r   <= best_nxt;
    sstart_r <= sstart_nxt;
    if (st_r == asdq_pkg::ST_OUT && out_free) begin
      out_status_r <= stat_r;
      out_ent_r    <= best_r;
      out_sstart_r <= sstart_r;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    stat_nxt      = stat_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    pick_nxt      = pick_r;
    clk_nxt       = clk_r;
    new_nxt       = new_r;
    best_nxt      = best_r;
    sstart_nxt    = sstart_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = k_r[AW-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = '0;
    unique case (st_r)
      asdq_pkg::ST_IDLE: begin
        if (in_valid) begin
          new_nxt    = {in_route_id, in_send_time, in_arrival_time, in_deadline_in};
          best_nxt   = '0;
          sstart_nxt = '0;
          stat_nxt   = asdq_pkg::STAT_OK;
          if (in_cmd == asdq_pkg::CMD_INSERT) begin
            if (cnt_r == CW'(QUEUE_DEPTH)) begin
              stat_nxt = asdq_pkg::STAT_FULL;
              st_nxt   = asdq_pkg::ST_OUT;
            end else if (cnt_r == '0) begin
              k_nxt  = '0;
              st_nxt = asdq_pkg::ST_INS_WR;
            end else begin
              k_nxt     = cnt_r;
              ram_raddr = cnt_m1[AW-1:0];
              st_nxt    = asdq_pkg::ST_INS_CMP;
            end
          end else begin
            if (cnt_r == '0) begin
              stat_nxt = asdq_pkg::STAT_EMPTY;
              st_nxt   = asdq_pkg::ST_OUT;
            end else begin
              st_nxt = asdq_pkg::ST_SRV_HEAD;
            end
          end
        end
      end
      asdq_pkg::ST_INS_CMP: begin
        if (rd_arr > new_arr) begin
          ram_we = 1'b1;
          k_nxt  = k_dec;
          if (k_r == CW'(1)) begin
            st_nxt = asdq_pkg::ST_INS_WR;
          end else begin
            ram_raddr = k_dec2[AW-1:0];
          end
        end else begin
          st_nxt = asdq_pkg::ST_INS_WR;
        end
      end
      asdq_pkg::ST_INS_WR: begin
        ram_we    = 1'b1;
        ram_wdata = new_r;
        cnt_nxt   = cnt_r + CW'(1);
        st_nxt    = asdq_pkg::ST_OUT;
      end
      asdq_pkg::ST_SRV_HEAD: begin
        best_nxt = ram_rdata;
        pick_nxt = '0;
        st_nxt   = asdq_pkg::ST_REM;
        if (mode_r == asdq_pkg::MODE_FIFO) begin
          if (rd_arr > clk_r) begin
            clk_nxt = rd_arr;
          end
        end else if (clk_r > rd_arr) begin
          k_nxt = CW'(1);
          if (cnt_r > CW'(1)) begin
            ram_raddr = AW'(1);
            st_nxt    = asdq_pkg::ST_SRV_SCAN;
          end
        end else begin
          clk_nxt = rd_arr;
        end
      end
      asdq_pkg::ST_SRV_SCAN: begin
        if (rd_arr < clk_r) begin
          if ($signed(rd_dl) < $signed(best_dl)) begin
            best_nxt = ram_rdata;
            pick_nxt = k_r;
          end
          if (k_inc < cnt_r) begin
            k_nxt     = k_inc;
            ram_raddr = k_inc[AW-1:0];
          end else begin
            st_nxt = asdq_pkg::ST_REM;
          end
        end else begin
          st_nxt = asdq_pkg::ST_REM;
        end
      end
      asdq_pkg::ST_REM: begin
        if (pick_inc < cnt_r) begin
          ram_raddr = pick_inc[AW-1:0];
          k_nxt     = pick_inc;
          st_nxt    = asdq_pkg::ST_REM_MV;
        end else begin
          st_nxt = asdq_pkg::ST_FIN;
        end
      end
      asdq_pkg::ST_REM_MV: begin
        ram_we    = 1'b1;
        ram_waddr = k_dec[AW-1:0];
        if (k_inc < cnt_r) begin
          ram_raddr = k_inc[AW-1:0];
          k_nxt     = k_inc;
        end else begin
          st_nxt = asdq_pkg::ST_FIN;
        end
      end
      asdq_pkg::ST_FIN: begin
        cnt_nxt    = cnt_m1;
        sstart_nxt = clk_r;
        clk_nxt    = clk_sum[TW] ? '1 : clk_sum[TW-1:0];
        st_nxt     = asdq_pkg::ST_OUT;
      end
      asdq_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          st_nxt        = asdq_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = asdq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_route         = out_ent_r[EW-1:3*TW];
  assign out_send_time     = out_ent_r[3*TW-1:2*TW];
  assign out_arrival       = out_ent_r[2*TW-1:TW];
  assign out_deadline      = out_ent_r[TW-1:0];
  assign out_service_start = out_sstart_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> clk_r >= $past(clk_r))
    else $error("service clock moved backward");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != asdq_pkg::ST_INS_WR && st_r != asdq_pkg::ST_FIN) |=> $stable(cnt_r))
    else $error("entry count changed outside an insert or serve completion");

endmodule

FILE: bench/tb_arrival_sorted_deadline_queue.sv
`timescale 1ns / 1ps
// Self-checking bench for the arrival-sorted deadline queue, with scoreboard and random traffic.

class queue_scoreboard;
  logic [31:0] arr_q[$];
  logic [31:0] snd_q[$];
  logic [31:0] dl_q[$];
  logic [7:0]  rt_q[$];
  logic [31:0] svc_clock;
  logic        mode;
  logic [15:0] pkt_size;
  logic [1:0]  exp_status[$];
  logic [7:0]  exp_route[$];
  logic [31:0] exp_send[$];
  logic [31:0] exp_arr[$];
  logic [31:0] exp_dl[$];
  logic [31:0] exp_start[$];
  int          errors;

  function new();
    svc_clock = '0;
    mode = 1'b0;
    pkt_size = 16'd1;
    errors = 0;
  endfunction

  function int depth();
    return arr_q.size();
  endfunction

  function int pending();
    return exp_status.size();
  endfunction

  function void push_result(logic [1:0] s, logic [7:0] r, logic [31:0] sd, logic [31:0] a,
                            logic [31:0] d, logic [31:0] st);
    exp_status.push_back(s);
    exp_route.push_back(r);
    exp_send.push_back(sd);
    exp_arr.push_back(a);
    exp_dl.push_back(d);
    exp_start.push_back(st);
  endfunction

  function void note_transfer(logic c, logic [7:0] r, logic [31:0] sd, logic [31:0] a,
                              logic [31:0] d);
    int pos;
    int pick;
    logic signed [31:0] best;
    logic [32:0] nxt;
    if (c == asdq_pkg::CMD_INSERT) begin
      if (arr_q.size() >= asdq_pkg::QUEUE_DEPTH_DEF) begin
        push_result(asdq_pkg::STAT_FULL, '0, '0, '0, '0, '0);
        return;
      end
      pos = arr_q.size();
      while (pos > 0 && arr_q[pos-1] > a) pos--;
      arr_q.insert(pos, a);
      snd_q.insert(pos, sd);
      dl_q.insert(pos, d);
      rt_q.insert(pos, r);
      push_result(asdq_pkg::STAT_OK, '0, '0, '0, '0, '0);
      return;
    end
    if (arr_q.size() == 0) begin
      push_result(asdq_pkg::STAT_EMPTY, '0, '0, '0, '0, '0);
      return;
    end
    pick = 0;
    if (mode == asdq_pkg::MODE_FIFO) begin
      if (arr_q[0] > svc_clock) svc_clock = arr_q[0];
    end else if (svc_clock > arr_q[0]) begin
      best = dl_q[0];
      for (int k = 1; k < arr_q.size() && arr_q[k] < svc_clock; k++)
        if ($signed(dl_q[k]) < best) begin
          best = dl_q[k];
          pick = k;
        end
    end else begin
      svc_clock = arr_q[0];
    end
    push_result(asdq_pkg::STAT_OK, rt_q[pick], snd_q[pick], arr_q[pick], dl_q[pick],
                svc_clock);
    arr_q.delete(pick);
    snd_q.delete(pick);
    dl_q.delete(pick);
    rt_q.delete(pick);
    nxt = {1'b0, svc_clock} + {17'd0, pkt_size};
    svc_clock = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
  endfunction

  function void check_result(logic [1:0] s, logic [7:0] r, logic [31:0] sd, logic [31:0] a,
                             logic [31:0] d, logic [31:0] st);
    if (exp_status.size() == 0) begin
      $error("unexpected result, status %0d", s);
      errors++;
      return;
    end
    if (s !== exp_status[0]) begin
      $error("status: expected %0d, actual %0d", exp_status[0], s); errors++;
    end
    if (r !== exp_route[0]) begin
      $error("out_route: expected %0h, actual %0h", exp_route[0], r); errors++;
    end
    if (sd !== exp_send[0]) begin
      $error("out_send_time: expected %0h, actual %0h", exp_send[0], sd); errors++;
    end
    if (a !== exp_arr[0]) begin
      $error("out_arrival: expected %0h, actual %0h", exp_arr[0], a); errors++;
    end
    if (d !== exp_dl[0]) begin
      $error("out_deadline: expected %0h, actual %0h", exp_dl[0], d); errors++;
    end
    if (st !== exp_start[0]) begin
      $error("service_start: expected %0h, actual %0h", exp_start[0], st); errors++;
    end
    void'(exp_status.pop_front());
    void'(exp_route.pop_front());
    void'(exp_send.pop_front());
    void'(exp_arr.pop_front());
    void'(exp_dl.pop_front());
    void'(exp_start.pop_front());
  endfunction
endclass

module tb_arrival_sorted_deadline_queue;
  logic                           clk;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [asdq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [asdq_pkg::SIZE_W-1:0]    cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic                           in_cmd;
  logic [7:0]                     in_route_id;
  logic [31:0]                    in_send_time;
  logic [31:0]                    in_arrival_time;
  logic signed [31:0]             in_deadline_in;
  logic                           out_valid;
  logic                           out_stall;
  logic [1:0]                     out_status;
  logic [7:0]                     out_route;
  logic [31:0]                    out_send_time;
  logic [31:0]                    out_arrival;
  logic signed [31:0]             out_deadline;
  logic [31:0]                    out_service_start;

  queue_scoreboard board;
  int  cycles = 0;
  bit  calm;
  bit  hold_req;
  bit  hold_done;
  logic [31:0] arr_base;

  arrival_sorted_deadline_queue dut (.*);

  initial begin
    clk = 1'b0;
  end
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb_arrival_sorted_deadline_queue: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_status, out_route, out_send_time, out_arrival,
                         out_deadline, out_service_start);
  end

  initial begin
    int n;
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(logic c, logic [7:0] r, logic [31:0] sd, logic [31:0] a,
                           logic [31:0] d);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_route_id <= r;
    in_send_time <= sd;
    in_arrival_time <= a;
    in_deadline_in <= d;
    do @(posedge clk); while (in_stall);
    board.note_transfer(c, r, sd, a, d);
  endtask

  task automatic write_reg(logic [asdq_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == asdq_pkg::CFG_SERVE_MODE) board.mode = val[0];
    else if (idx == asdq_pkg::CFG_PACKET_SIZE) board.pkt_size = val;
  endtask

  task automatic random_phase(int count, int spread);
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      arr_base += $urandom_range(0, spread);
      case ($urandom_range(0, 9))
        0: a = $urandom();
        1: a = arr_base;
        default: a = arr_base + $urandom_range(0, spread * 4);
      endcase
      send_item(($urandom_range(0, 99) < 48) ? asdq_pkg::CMD_SERVE : asdq_pkg::CMD_INSERT,
                8'($urandom()), $urandom(),
                a, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom());
    end
  endtask

  initial begin
    board = new();
    calm = 0;
    hold_req = 0;
    arr_base = '0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_cmd = asdq_pkg::CMD_INSERT;
    in_route_id = '0;
    in_send_time = '0;
    in_arrival_time = '0;
    in_deadline_in = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty serve, extremes, ties, deadline-mode serve, saturation.
    send_item(asdq_pkg::CMD_SERVE, '0, '0, '0, '0);
    send_item(asdq_pkg::CMD_INSERT, 8'hFF, 32'hFFFF_FFFF, 32'd10, 32'h7FFF_FFFF);
    send_item(asdq_pkg::CMD_INSERT, 8'h00, 32'd0, 32'd10, 32'h8000_0000);
    send_item(asdq_pkg::CMD_INSERT, 8'h5A, 32'h1234_5678, 32'd5, 32'd3);
    send_item(asdq_pkg::CMD_INSERT, 8'hA5, 32'hA5A5_A5A5, 32'd0, 32'd3);
    send_item(asdq_pkg::CMD_SERVE, '0, '0, '0, '0);
    send_item(asdq_pkg::CMD_SERVE, '0, '0, '0, '0);
    send_item(asdq_pkg::CMD_INSERT, 8'h11, 32'd1, 32'd7, 32'd3);
    send_item(asdq_pkg::CMD_SERVE, '0, '0, '0, '0);
    send_item(asdq_pkg::CMD_SERVE, '0, '0, '0, '0);
    send_item(asdq_pkg::CMD_SERVE, '0, '0, '0, '0);
    send_item(asdq_pkg::CMD_SERVE, '0, '0, '0, '0);
    write_reg(asdq_pkg::CFG_PACKET_SIZE, 16'hFFFF);
    write_reg(asdq_pkg::CFG_SERVE_MODE, 16'(asdq_pkg::MODE_FIFO));
    send_item(asdq_pkg::CMD_INSERT, 8'h3C, 32'd9, 32'hFFFF_FFF0, 32'd1);
    send_item(asdq_pkg::CMD_INSERT, 8'hC3, 32'd8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(asdq_pkg::CMD_SERVE, '0, '0, '0, '0);
    send_item(asdq_pkg::CMD_SERVE, '0, '0, '0, '0);
    send_item(asdq_pkg::CMD_SERVE, '0, '0, '0, '0);

    // Fill past capacity while the receiver holds off.
    hold_req = 1;
    for (int i = 0; i < asdq_pkg::QUEUE_DEPTH_DEF + 3; i++)
      send_item(asdq_pkg::CMD_INSERT, 8'($urandom()), $urandom(), $urandom_range(0, 50),
                $urandom());
    write_reg(asdq_pkg::CFG_SERVE_MODE, 16'd0);
    write_reg(asdq_pkg::CFG_PACKET_SIZE, 16'd0);
    for (int i = 0; i < asdq_pkg::QUEUE_DEPTH_DEF + 1; i++)
      send_item(asdq_pkg::CMD_SERVE, '0, '0, '0, '0);

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(asdq_pkg::CFG_SERVE_MODE, 16'(ph[0]));
      write_reg(asdq_pkg::CFG_PACKET_SIZE, (ph == 5) ? 16'hFFFF : 16'($urandom_range(0, 40)));
      arr_base = (ph == 5) ? 32'hFFFF_0000 : board.svc_clock;
      if (ph == 5) calm = 1;
      random_phase(300, 20);
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("tb_arrival_sorted_deadline_queue: done, clean");
    else
      $display("tb_arrival_sorted_deadline_queue: done, errors");
    $finish;
  end
endmodule
